// ----- sv/n6502_pkg.sv -----
// Package: beat types, opcode codes and field constants of the unofficial opcode ALU.
package n6502_pkg;

  typedef struct packed {
    logic [7:0] kind;
    logic [7:0] operand;
    logic [7:0] reg_a;
    logic [7:0] reg_x;
    logic [7:0] reg_y;
    logic [7:0] reg_sp;
    logic [3:0] flags_in;
    logic [7:0] addr_high;
    logic       page_cross;
  } req_t;

  typedef struct packed {
    logic [7:0] new_a;
    logic [7:0] new_x;
    logic [7:0] new_sp;
    logic [3:0] flags_out;
    logic       write_enable;
    logic [7:0] write_data;
    logic [3:0] cycle_count;
    logic       halt;
    logic       handled;
  } res_t;

  // flag positions
  localparam int unsigned FlagN = 3;
  localparam int unsigned FlagV = 2;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [7:0] SignBit  = 8'h80;
  localparam logic [7:0] Bit6Mask = 8'h40;
  localparam logic [7:0] Bit5Mask = 8'h20;

  // read-modify-write columns (low five opcode bits)
  localparam logic [4:0] ColIzx = 5'h03;
  localparam logic [4:0] ColZp  = 5'h07;
  localparam logic [4:0] ColAbs = 5'h0F;
  localparam logic [4:0] ColIzy = 5'h13;
  localparam logic [4:0] ColZpx = 5'h17;
  localparam logic [4:0] ColAby = 5'h1B;
  localparam logic [4:0] ColAbx = 5'h1F;

  // read-modify-write groups (top three opcode bits)
  localparam logic [2:0] GrpSlo   = 3'd0;
  localparam logic [2:0] GrpRla   = 3'd1;
  localparam logic [2:0] GrpSre   = 3'd2;
  localparam logic [2:0] GrpRra   = 3'd3;
  localparam logic [2:0] GrpStore = 3'd4;
  localparam logic [2:0] GrpLoad  = 3'd5;
  localparam logic [2:0] GrpDcp   = 3'd6;
  localparam logic [2:0] GrpIsb   = 3'd7;

  // jam opcodes
  localparam logic [7:0] OpKil02 = 8'h02, OpKil12 = 8'h12, OpKil22 = 8'h22;
  localparam logic [7:0] OpKil32 = 8'h32, OpKil42 = 8'h42, OpKil52 = 8'h52;
  localparam logic [7:0] OpKil62 = 8'h62, OpKil72 = 8'h72, OpKil92 = 8'h92;
  localparam logic [7:0] OpKilB2 = 8'hB2, OpKilD2 = 8'hD2, OpKilF2 = 8'hF2;

  // nops reported with the minimum cycle count
  localparam logic [7:0] OpNop1A = 8'h1A, OpNop3A = 8'h3A, OpNop5A = 8'h5A;
  localparam logic [7:0] OpNop7A = 8'h7A, OpNopDA = 8'hDA, OpNopFA = 8'hFA;
  localparam logic [7:0] OpNop80 = 8'h80, OpNop82 = 8'h82, OpNop89 = 8'h89;
  localparam logic [7:0] OpNopC2 = 8'hC2, OpNopE2 = 8'hE2;

  // zero page nops
  localparam logic [7:0] OpNop04 = 8'h04, OpNop44 = 8'h44, OpNop64 = 8'h64;

  // zero page,X and absolute nops
  localparam logic [7:0] OpNop14 = 8'h14, OpNop34 = 8'h34, OpNop54 = 8'h54;
  localparam logic [7:0] OpNop74 = 8'h74, OpNopD4 = 8'hD4, OpNopF4 = 8'hF4;
  localparam logic [7:0] OpNop0C = 8'h0C;

  // absolute,X nops
  localparam logic [7:0] OpNop1C = 8'h1C, OpNop3C = 8'h3C, OpNop5C = 8'h5C;
  localparam logic [7:0] OpNop7C = 8'h7C, OpNopDC = 8'hDC, OpNopFC = 8'hFC;

  localparam logic [7:0] OpSaxIzx = 8'h83, OpSaxZp = 8'h87;
  localparam logic [7:0] OpSaxAbs = 8'h8F, OpSaxZpy = 8'h97;

  localparam logic [7:0] OpLaxIzx = 8'hA3, OpLaxZp = 8'hA7, OpLaxAbs = 8'hAF;
  localparam logic [7:0] OpLaxIzy = 8'hB3, OpLaxZpy = 8'hB7, OpLaxAby = 8'hBF;
  localparam logic [7:0] OpLaxImm = 8'hAB;

  localparam logic [7:0] OpAnc0B = 8'h0B, OpAnc2B = 8'h2B;
  localparam logic [7:0] OpAlr   = 8'h4B, OpArr = 8'h6B, OpXaa = 8'h8B;
  localparam logic [7:0] OpAxs   = 8'hCB, OpSbcEB = 8'hEB;
  localparam logic [7:0] OpShaIzy = 8'h93, OpShaAby = 8'h9F;
  localparam logic [7:0] OpShy   = 8'h9C, OpShx = 8'h9E, OpTas = 8'h9B;
  localparam logic [7:0] OpLas   = 8'hBB;

  localparam logic [3:0] CycMin = 4'd2;
  localparam logic [3:0] CycMax = 4'd8;

endpackage

// ----- sv/nmos6502_unofficial_opcode_alu_core.sv -----
// Top level: registered execute unit for the undocumented NMOS 6502 opcodes.
//
// One instruction beat is taken at every rising edge with start high; busy stays
// low, so beats can follow back to back, one per cycle. The beat is registered,
// decoded and executed through one pass of 8-bit logic (the 9-bit adder and the
// flag logic after it set the path), and the result is registered in res_q and
// appears on res_o, marked by valid_o, which is high for a single cycle per result.
// The receiver cannot stall; it must take each result when valid_o is high.
// Decimal mode is not modelled.
module nmos6502_unofficial_opcode_alu_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  n6502_pkg::req_t req_i,
  output logic            valid_o,
  output n6502_pkg::res_t res_o
);

  logic            in_valid_q;
  n6502_pkg::req_t in_q;
  logic            out_valid_q;
  n6502_pkg::res_t res_q;
  n6502_pkg::res_t res_d;

  assign busy    = 1'b0;
  assign valid_o = out_valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start;
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= req_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  function automatic logic [6:0] a_and_m_hi(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] t;
    t = a & b;
    return t[7:1];
  endfunction

  // execute
  logic [7:0] op;
  logic [4:0] col;
  logic [2:0] grp;
  logic [7:0] m;
  logic [7:0] hmask;
  logic [7:0] a_and_x;
  logic       c_in;
  logic       is_rmw;
  logic [7:0] mod_m;     // modified memory byte of a read-modify-write
  logic [7:0] add_b;     // adder operand
  logic       add_cin;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] cmp_a;
  logic [7:0] cmp_b;
  logic [7:0] arr_r;
  logic [7:0] t_and;

  assign op      = in_q.kind;
  assign col     = op[4:0];
  assign grp     = op[7:5];
  assign m       = in_q.operand;
  assign hmask   = in_q.addr_high + 8'd1;
  assign a_and_x = in_q.reg_a & in_q.reg_x;
  assign c_in    = in_q.flags_in[n6502_pkg::FlagC];
  assign is_rmw  = (col == n6502_pkg::ColIzx || col == n6502_pkg::ColZp ||
                    col == n6502_pkg::ColAbs || col == n6502_pkg::ColIzy ||
                    col == n6502_pkg::ColZpx || col == n6502_pkg::ColAby ||
                    col == n6502_pkg::ColAbx) &&
                   grp != n6502_pkg::GrpStore && grp != n6502_pkg::GrpLoad;

  always_comb begin
    unique case (grp)
      n6502_pkg::GrpSlo: mod_m = {m[6:0], 1'b0};
      n6502_pkg::GrpRla: mod_m = {m[6:0], c_in};
      n6502_pkg::GrpSre: mod_m = {1'b0, m[7:1]};
      n6502_pkg::GrpRra: mod_m = {c_in, m[7:1]};
      n6502_pkg::GrpDcp: mod_m = m - 8'd1;
      n6502_pkg::GrpIsb: mod_m = m + 8'd1;
      default:           mod_m = m;
    endcase
  end

  // RRA adds the rotated byte; ISB and SBC add the inverted byte
  always_comb begin
    if (is_rmw && grp == n6502_pkg::GrpRra) begin
      add_b = mod_m;
    end else if (is_rmw) begin
      add_b = ~mod_m;
    end else begin
      add_b = ~m;
    end
  end

  // RRA feeds the bit rotated out of the byte into the add
  assign add_cin = (is_rmw && grp == n6502_pkg::GrpRra) ? m[0] : c_in;
  assign sum = {1'b0, in_q.reg_a} + {1'b0, add_b} + {8'd0, add_cin};

  // DCP compares A with the decremented byte; AXS compares A&X with the operand
  assign cmp_a = is_rmw ? in_q.reg_a : a_and_x;
  assign cmp_b = is_rmw ? mod_m : m;
  assign diff  = {1'b0, cmp_a} - {1'b0, cmp_b};

  assign arr_r = {c_in, a_and_m_hi(in_q.reg_a, m)};
  assign t_and = m & in_q.reg_sp;

  always_comb begin
    logic       n, v, z, c;
    logic [7:0] r;
    logic       nz_upd;
    logic [7:0] sum_r;
    sum_r = sum[7:0];
    n = in_q.flags_in[n6502_pkg::FlagN];
    v = in_q.flags_in[n6502_pkg::FlagV];
    z = in_q.flags_in[n6502_pkg::FlagZ];
    c = c_in;
    r = 8'd0;
    nz_upd = 1'b0;
    res_d = '0;
    res_d.new_a       = in_q.reg_a;
    res_d.new_x       = in_q.reg_x;
    res_d.new_sp      = in_q.reg_sp;
    res_d.cycle_count = n6502_pkg::CycMin;
    res_d.handled     = 1'b1;

    if (is_rmw) begin
      unique case (grp)
        n6502_pkg::GrpSlo: begin
          c = m[7];
          res_d.new_a = in_q.reg_a | mod_m;
        end
        n6502_pkg::GrpRla: begin
          c = m[7];
          res_d.new_a = in_q.reg_a & mod_m;
        end
        n6502_pkg::GrpSre: begin
          c = m[0];
          res_d.new_a = in_q.reg_a ^ mod_m;
        end
        n6502_pkg::GrpDcp: begin
          c = ~diff[8];
        end
        default: begin
          // RRA and ISB add through the shared adder
          c = sum[8];
          v = ((~(in_q.reg_a ^ add_b)) & (in_q.reg_a ^ sum_r) & n6502_pkg::SignBit) != 8'd0;
          res_d.new_a = sum_r;
        end
      endcase
      r = (grp == n6502_pkg::GrpDcp) ? diff[7:0] : res_d.new_a;
      nz_upd = 1'b1;
      res_d.write_enable = 1'b1;
      res_d.write_data   = mod_m;
      unique case (col)
        n6502_pkg::ColIzx: res_d.cycle_count = 4'd8;
        n6502_pkg::ColZp:  res_d.cycle_count = 4'd5;
        n6502_pkg::ColAbs: res_d.cycle_count = 4'd6;
        n6502_pkg::ColIzy: res_d.cycle_count = 4'd8;
        n6502_pkg::ColZpx: res_d.cycle_count = 4'd6;
        default:           res_d.cycle_count = 4'd7;
      endcase
    end else begin
      unique case (op)
        n6502_pkg::OpKil02, n6502_pkg::OpKil12, n6502_pkg::OpKil22,
        n6502_pkg::OpKil32, n6502_pkg::OpKil42, n6502_pkg::OpKil52,
        n6502_pkg::OpKil62, n6502_pkg::OpKil72, n6502_pkg::OpKil92,
        n6502_pkg::OpKilB2, n6502_pkg::OpKilD2, n6502_pkg::OpKilF2: begin
          res_d.halt = 1'b1;
        end
        n6502_pkg::OpNop1A, n6502_pkg::OpNop3A, n6502_pkg::OpNop5A,
        n6502_pkg::OpNop7A, n6502_pkg::OpNopDA, n6502_pkg::OpNopFA,
        n6502_pkg::OpNop80, n6502_pkg::OpNop82, n6502_pkg::OpNop89,
        n6502_pkg::OpNopC2, n6502_pkg::OpNopE2: begin
          res_d.cycle_count = n6502_pkg::CycMin;
        end
        n6502_pkg::OpNop04, n6502_pkg::OpNop44, n6502_pkg::OpNop64: begin
          res_d.cycle_count = 4'd3;
        end
        n6502_pkg::OpNop14, n6502_pkg::OpNop34, n6502_pkg::OpNop54,
        n6502_pkg::OpNop74, n6502_pkg::OpNopD4, n6502_pkg::OpNopF4,
        n6502_pkg::OpNop0C: begin
          res_d.cycle_count = 4'd4;
        end
        n6502_pkg::OpNop1C, n6502_pkg::OpNop3C, n6502_pkg::OpNop5C,
        n6502_pkg::OpNop7C, n6502_pkg::OpNopDC, n6502_pkg::OpNopFC: begin
          res_d.cycle_count = 4'd4 + {3'd0, in_q.page_cross};
        end
        n6502_pkg::OpSaxIzx, n6502_pkg::OpSaxZp,
        n6502_pkg::OpSaxAbs, n6502_pkg::OpSaxZpy: begin
          res_d.write_enable = 1'b1;
          res_d.write_data   = a_and_x;
          if (op == n6502_pkg::OpSaxIzx) begin
            res_d.cycle_count = 4'd6;
          end else if (op == n6502_pkg::OpSaxZp) begin
            res_d.cycle_count = 4'd3;
          end else begin
            res_d.cycle_count = 4'd4;
          end
        end
        n6502_pkg::OpLaxIzx, n6502_pkg::OpLaxZp, n6502_pkg::OpLaxAbs,
        n6502_pkg::OpLaxIzy, n6502_pkg::OpLaxZpy, n6502_pkg::OpLaxAby,
        n6502_pkg::OpLaxImm: begin
          res_d.new_a = m;
          res_d.new_x = m;
          r = m;
          nz_upd = 1'b1;
          unique case (op)
            n6502_pkg::OpLaxIzx: res_d.cycle_count = 4'd6;
            n6502_pkg::OpLaxZp:  res_d.cycle_count = 4'd3;
            n6502_pkg::OpLaxIzy: res_d.cycle_count = 4'd5 + {3'd0, in_q.page_cross};
            n6502_pkg::OpLaxAby: res_d.cycle_count = 4'd4 + {3'd0, in_q.page_cross};
            n6502_pkg::OpLaxImm: res_d.cycle_count = n6502_pkg::CycMin;
            default:             res_d.cycle_count = 4'd4;
          endcase
        end
        n6502_pkg::OpAnc0B, n6502_pkg::OpAnc2B: begin
          r = in_q.reg_a & m;
          res_d.new_a = r;
          nz_upd = 1'b1;
          c = r[7];
        end
        n6502_pkg::OpAlr: begin
          r = {1'b0, a_and_m_hi(in_q.reg_a, m)};
          c = in_q.reg_a[0] & m[0];
          res_d.new_a = r;
          nz_upd = 1'b1;
        end
        n6502_pkg::OpArr: begin
          r = arr_r;
          c = (arr_r & n6502_pkg::Bit6Mask) != 8'd0;
          v = ((arr_r & n6502_pkg::Bit6Mask) != 8'd0) !=
              ((arr_r & n6502_pkg::Bit5Mask) != 8'd0);
          res_d.new_a = r;
          nz_upd = 1'b1;
        end
        n6502_pkg::OpXaa: begin
          r = in_q.reg_x & m;
          res_d.new_a = r;
          nz_upd = 1'b1;
        end
        n6502_pkg::OpAxs: begin
          c = ~diff[8];
          r = diff[7:0];
          res_d.new_x = r;
          nz_upd = 1'b1;
        end
        n6502_pkg::OpSbcEB: begin
          c = sum[8];
          v = ((~(in_q.reg_a ^ add_b)) & (in_q.reg_a ^ sum_r) & n6502_pkg::SignBit) != 8'd0;
          r = sum_r;
          res_d.new_a = r;
          nz_upd = 1'b1;
        end
        n6502_pkg::OpShaIzy, n6502_pkg::OpShaAby: begin
          res_d.write_enable = 1'b1;
          res_d.write_data   = a_and_x & hmask;
          res_d.cycle_count  = (op == n6502_pkg::OpShaIzy) ? 4'd6 : 4'd5;
        end
        n6502_pkg::OpShy: begin
          res_d.write_enable = 1'b1;
          res_d.write_data   = in_q.reg_y & hmask;
          res_d.cycle_count  = 4'd5;
        end
        n6502_pkg::OpShx: begin
          res_d.write_enable = 1'b1;
          res_d.write_data   = in_q.reg_x & hmask;
          res_d.cycle_count  = 4'd5;
        end
        n6502_pkg::OpTas: begin
          res_d.new_sp       = a_and_x;
          res_d.write_enable = 1'b1;
          res_d.write_data   = a_and_x & hmask;
          res_d.cycle_count  = 4'd5;
        end
        n6502_pkg::OpLas: begin
          r = t_and;
          res_d.new_a  = t_and;
          res_d.new_x  = t_and;
          res_d.new_sp = t_and;
          nz_upd = 1'b1;
          res_d.cycle_count = 4'd4 + {3'd0, in_q.page_cross};
        end
        default: begin
          res_d.handled = 1'b0;
        end
      endcase
    end

    if (nz_upd) begin
      n = r[7];
      z = (r == 8'd0);
    end
    res_d.flags_out = {n, v, z, c};
  end

endmodule

// ----- sv/n6502_checker.sv -----
// Checker: port-level assertions for the unofficial opcode ALU, bound to the top level.
module n6502_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input n6502_pkg::req_t req_i,
  input logic            valid_o,
  input n6502_pkg::res_t res_o
);

  // every accepted beat yields a result on valid_o, through the input and output registers
  a_beat_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 valid_o)
    else $error("accepted beat produced no result");

  // no result without an accepted beat
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 2))
    else $error("result without accepted beat");

  a_halt_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.halt |->
      res_o.handled && !res_o.write_enable && res_o.cycle_count == n6502_pkg::CycMin)
    else $error("halt result malformed");

  a_no_write_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.write_enable |-> res_o.write_data == 8'd0)
    else $error("write data without write enable");

  a_cycle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.cycle_count >= n6502_pkg::CycMin &&
                res_o.cycle_count <= n6502_pkg::CycMax)
    else $error("cycle count out of range");

endmodule

bind nmos6502_unofficial_opcode_alu_core n6502_checker u_n6502_checker (.*);

// ----- tb/testbench.sv -----
// Testbench: directed and random instruction beats checked against a behavioral execute model.

class exec_scoreboard;
  n6502_pkg::res_t expected_q[$];
  int unsigned     mismatches;
  int unsigned     beats_in;
  int unsigned     results_out;
  int unsigned     halts;
  int unsigned     writes;
  int unsigned     unhandled;

  function new();
    mismatches  = 0;
    beats_in    = 0;
    results_out = 0;
    halts       = 0;
    writes      = 0;
    unhandled   = 0;
  endfunction

  // binary add with carry in: returns {carry, overflow, sum}
  function automatic logic [9:0] add_with_carry(logic [7:0] a, logic [7:0] m, logic cin);
    logic [8:0] sum;
    logic       ovf;
    sum = {1'b0, a} + {1'b0, m} + {8'd0, cin};
    ovf = ((~(a ^ m)) & (a ^ sum[7:0]) & n6502_pkg::SignBit) != 8'd0;
    return {sum[8], ovf, sum[7:0]};
  endfunction

  function automatic n6502_pkg::res_t execute(n6502_pkg::req_t q);
    n6502_pkg::res_t o;
    logic [7:0] a, x, sp, m, hmask, r, t;
    logic       n, v, z, c, nc;
    logic [9:0] acc;
    logic [4:0] col;
    logic [2:0] grp;
    logic [3:0] cyc;
    logic       we, hlt, hnd, rmw;
    logic [7:0] wd;

    a     = q.reg_a;
    x     = q.reg_x;
    sp    = q.reg_sp;
    m     = q.operand;
    hmask = q.addr_high + 8'd1;
    n     = q.flags_in[n6502_pkg::FlagN];
    v     = q.flags_in[n6502_pkg::FlagV];
    z     = q.flags_in[n6502_pkg::FlagZ];
    c     = q.flags_in[n6502_pkg::FlagC];
    col   = q.kind[4:0];
    grp   = q.kind[7:5];
    we    = 1'b0;
    wd    = 8'd0;
    cyc   = n6502_pkg::CycMin;
    hlt   = 1'b0;
    hnd   = 1'b1;
    rmw   = 1'b0;

    case (col)
      n6502_pkg::ColIzx, n6502_pkg::ColZp, n6502_pkg::ColAbs, n6502_pkg::ColIzy,
      n6502_pkg::ColZpx, n6502_pkg::ColAby, n6502_pkg::ColAbx:
        rmw = (grp != n6502_pkg::GrpStore) && (grp != n6502_pkg::GrpLoad);
      default: rmw = 1'b0;
    endcase

    if (rmw) begin
      case (grp)
        n6502_pkg::GrpSlo: begin
          c = m[7];
          m = m << 1;
          a = a | m;
          n = a[7]; z = (a == 8'd0);
        end
        n6502_pkg::GrpRla: begin
          nc = m[7];
          m  = {m[6:0], c};
          c  = nc;
          a  = a & m;
          n = a[7]; z = (a == 8'd0);
        end
        n6502_pkg::GrpSre: begin
          c = m[0];
          m = m >> 1;
          a = a ^ m;
          n = a[7]; z = (a == 8'd0);
        end
        n6502_pkg::GrpRra: begin
          nc  = m[0];
          m   = {c, m[7:1]};
          acc = add_with_carry(a, m, nc);
          c = acc[9]; v = acc[8]; a = acc[7:0];
          n = a[7]; z = (a == 8'd0);
        end
        n6502_pkg::GrpDcp: begin
          m = m - 8'd1;
          c = (a >= m);
          r = a - m;
          n = r[7]; z = (r == 8'd0);
        end
        default: begin
          m   = m + 8'd1;
          acc = add_with_carry(a, ~m, c);
          c = acc[9]; v = acc[8]; a = acc[7:0];
          n = a[7]; z = (a == 8'd0);
        end
      endcase
      we = 1'b1;
      wd = m;
      case (col)
        n6502_pkg::ColIzx: cyc = 4'd8;
        n6502_pkg::ColZp:  cyc = 4'd5;
        n6502_pkg::ColAbs: cyc = 4'd6;
        n6502_pkg::ColIzy: cyc = 4'd8;
        n6502_pkg::ColZpx: cyc = 4'd6;
        default:           cyc = 4'd7;
      endcase
    end else begin
      case (q.kind)
        n6502_pkg::OpKil02, n6502_pkg::OpKil12, n6502_pkg::OpKil22, n6502_pkg::OpKil32,
        n6502_pkg::OpKil42, n6502_pkg::OpKil52, n6502_pkg::OpKil62, n6502_pkg::OpKil72,
        n6502_pkg::OpKil92, n6502_pkg::OpKilB2, n6502_pkg::OpKilD2, n6502_pkg::OpKilF2:
          hlt = 1'b1;
        n6502_pkg::OpNop1A, n6502_pkg::OpNop3A, n6502_pkg::OpNop5A, n6502_pkg::OpNop7A,
        n6502_pkg::OpNopDA, n6502_pkg::OpNopFA, n6502_pkg::OpNop80, n6502_pkg::OpNop82,
        n6502_pkg::OpNop89, n6502_pkg::OpNopC2, n6502_pkg::OpNopE2: ;
        n6502_pkg::OpNop04, n6502_pkg::OpNop44, n6502_pkg::OpNop64:
          cyc = 4'd3;
        n6502_pkg::OpNop14, n6502_pkg::OpNop34, n6502_pkg::OpNop54, n6502_pkg::OpNop74,
        n6502_pkg::OpNopD4, n6502_pkg::OpNopF4, n6502_pkg::OpNop0C:
          cyc = 4'd4;
        n6502_pkg::OpNop1C, n6502_pkg::OpNop3C, n6502_pkg::OpNop5C, n6502_pkg::OpNop7C,
        n6502_pkg::OpNopDC, n6502_pkg::OpNopFC:
          cyc = 4'd4 + {3'd0, q.page_cross};
        n6502_pkg::OpSaxIzx, n6502_pkg::OpSaxZp, n6502_pkg::OpSaxAbs,
        n6502_pkg::OpSaxZpy: begin
          we = 1'b1;
          wd = a & x;
          cyc = (q.kind == n6502_pkg::OpSaxIzx) ? 4'd6 :
                ((q.kind == n6502_pkg::OpSaxZp) ? 4'd3 : 4'd4);
        end
        n6502_pkg::OpLaxIzx, n6502_pkg::OpLaxZp, n6502_pkg::OpLaxAbs,
        n6502_pkg::OpLaxIzy, n6502_pkg::OpLaxZpy, n6502_pkg::OpLaxAby,
        n6502_pkg::OpLaxImm: begin
          a = m;
          x = m;
          n = m[7]; z = (m == 8'd0);
          case (q.kind)
            n6502_pkg::OpLaxIzx: cyc = 4'd6;
            n6502_pkg::OpLaxZp:  cyc = 4'd3;
            n6502_pkg::OpLaxIzy: cyc = 4'd5 + {3'd0, q.page_cross};
            n6502_pkg::OpLaxAby: cyc = 4'd4 + {3'd0, q.page_cross};
            n6502_pkg::OpLaxImm: cyc = n6502_pkg::CycMin;
            default:             cyc = 4'd4;
          endcase
        end
        n6502_pkg::OpAnc0B, n6502_pkg::OpAnc2B: begin
          a = a & m;
          n = a[7]; z = (a == 8'd0);
          c = n;
        end
        n6502_pkg::OpAlr: begin
          a = a & m;
          c = a[0];
          a = a >> 1;
          n = a[7]; z = (a == 8'd0);
        end
        n6502_pkg::OpArr: begin
          r = ((a & m) >> 1) | (c ? n6502_pkg::SignBit : 8'd0);
          c = (r & n6502_pkg::Bit6Mask) != 8'd0;
          v = ((r & n6502_pkg::Bit6Mask) != 8'd0) != ((r & n6502_pkg::Bit5Mask) != 8'd0);
          a = r;
          n = r[7]; z = (r == 8'd0);
        end
        n6502_pkg::OpXaa: begin
          a = x & m;
          n = a[7]; z = (a == 8'd0);
        end
        n6502_pkg::OpAxs: begin
          t = a & x;
          c = (t >= m);
          x = t - m;
          n = x[7]; z = (x == 8'd0);
        end
        n6502_pkg::OpSbcEB: begin
          acc = add_with_carry(a, ~m, c);
          c = acc[9]; v = acc[8]; a = acc[7:0];
          n = a[7]; z = (a == 8'd0);
        end
        n6502_pkg::OpShaIzy, n6502_pkg::OpShaAby: begin
          we = 1'b1;
          wd = a & x & hmask;
          cyc = (q.kind == n6502_pkg::OpShaIzy) ? 4'd6 : 4'd5;
        end
        n6502_pkg::OpShy: begin
          we = 1'b1;
          wd = q.reg_y & hmask;
          cyc = 4'd5;
        end
        n6502_pkg::OpShx: begin
          we = 1'b1;
          wd = x & hmask;
          cyc = 4'd5;
        end
        n6502_pkg::OpTas: begin
          sp = a & x;
          we = 1'b1;
          wd = sp & hmask;
          cyc = 4'd5;
        end
        n6502_pkg::OpLas: begin
          t = m & sp;
          a = t; x = t; sp = t;
          n = t[7]; z = (t == 8'd0);
          cyc = 4'd4 + {3'd0, q.page_cross};
        end
        default: hnd = 1'b0;
      endcase
    end

    o.new_a        = a;
    o.new_x        = x;
    o.new_sp       = sp;
    o.flags_out    = {n, v, z, c};
    o.write_enable = we;
    o.write_data   = wd;
    o.cycle_count  = cyc;
    o.halt         = hlt;
    o.handled      = hnd;
    return o;
  endfunction

  function string show(n6502_pkg::res_t r);
    return $sformatf("a=%h x=%h sp=%h nvzc=%b we=%b wd=%h cyc=%0d halt=%b hnd=%b",
                     r.new_a, r.new_x, r.new_sp, r.flags_out, r.write_enable,
                     r.write_data, r.cycle_count, r.halt, r.handled);
  endfunction

  function void note_beat(n6502_pkg::req_t q);
    n6502_pkg::res_t want;
    want = execute(q);
    expected_q.push_back(want);
    beats_in++;
    if (want.halt) halts++;
    if (want.write_enable) writes++;
    if (!want.handled) unhandled++;
  endfunction

  function void check_result(n6502_pkg::res_t got);
    n6502_pkg::res_t want;
    logic bad;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: %s", show(got));
      return;
    end
    want = expected_q.pop_front();
    results_out++;
    bad = (got.new_a !== want.new_a) || (got.new_x !== want.new_x) ||
          (got.new_sp !== want.new_sp) || (got.flags_out !== want.flags_out) ||
          (got.write_enable !== want.write_enable) ||
          (got.write_data !== want.write_data) ||
          (got.cycle_count !== want.cycle_count) || (got.halt !== want.halt) ||
          (got.handled !== want.handled);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on result %0d", results_out);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module testbench;

  localparam logic [7:0] OpBrk    = 8'h00;
  localparam logic [7:0] OpLdaImm = 8'hA9;
  localparam int unsigned RandomBeats  = 1125;
  localparam int unsigned WatchdogMax  = 500;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  n6502_pkg::req_t req_i;
  logic            valid_o;
  n6502_pkg::res_t res_o;

  exec_scoreboard sb;
  logic [7:0]     covered_ops[$];
  int unsigned    quiet_cycles;

  nmos6502_unofficial_opcode_alu_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    sb     = new();
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample both sides on the edge; check before noting the new beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_result(res_o);
      if (start && !busy) sb.note_beat(req_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogMax) begin
      $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // bias toward the byte extremes now and then
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(19))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      4:       return 8'h01;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic n6502_pkg::req_t make_req(logic [7:0] kind, logic [7:0] operand,
                                               logic [7:0] a, logic [7:0] x,
                                               logic [7:0] y, logic [7:0] sp,
                                               logic [3:0] fl, logic [7:0] ah, logic pc);
    n6502_pkg::req_t r;
    r.kind       = kind;
    r.operand    = operand;
    r.reg_a      = a;
    r.reg_x      = x;
    r.reg_y      = y;
    r.reg_sp     = sp;
    r.flags_in   = fl;
    r.addr_high  = ah;
    r.page_cross = pc;
    return r;
  endfunction

  task automatic send_beat(input n6502_pkg::req_t r);
    req_i <= r;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // drop start for one cycle, on about 18 calls in a hundred
  task automatic maybe_idle();
    if ($urandom_range(99) < 18) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    n6502_pkg::req_t r;
    n6502_pkg::res_t probe;
    int unsigned i;
    int unsigned drain;

    #1;
    for (i = 0; i < 256; i++) begin
      r = make_req(8'(i), 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0);
      probe = sb.execute(r);
      if (probe.handled) covered_ops.push_back(8'(i));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats
    send_beat(make_req(n6502_pkg::OpKil02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpKilF2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF, 8'hFF,
                       1'b1));
    send_beat(make_req(n6502_pkg::OpXaa, 8'h5A, 8'h00, 8'hFF, 8'h12, 8'h34, 4'h0, 8'h00,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpXaa, 8'h0F, 8'hFF, 8'hF0, 8'h00, 8'h00, 4'hF, 8'h00,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpLaxImm, 8'h00, 8'h55, 8'hAA, 8'h00, 8'h00, 4'h8, 8'h00,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpLaxImm, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 4'h2, 8'h00,
                       1'b0));
    send_beat(make_req(OpBrk, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44, 4'hA, 8'h55, 1'b1));
    send_beat(make_req(OpLdaImm, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'h5, 8'hFF, 1'b0));
    send_beat(make_req(n6502_pkg::OpShaAby, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 4'h0, 8'hFF,
                       1'b1));
    send_beat(make_req(n6502_pkg::OpShaIzy, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 4'h0, 8'h7F,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpShx, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 4'h0, 8'h00,
                       1'b1));
    send_beat(make_req(n6502_pkg::OpShy, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 4'h0, 8'hFE,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpTas, 8'h00, 8'hF0, 8'h3C, 8'h00, 8'hFF, 4'h0, 8'h7F,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpNop1C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00,
                       1'b1));
    send_beat(make_req(n6502_pkg::OpNopFC, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpLas, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 4'h0, 8'h00,
                       1'b1));
    send_beat(make_req(n6502_pkg::OpLaxIzy, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00,
                       1'b1));
    send_beat(make_req({n6502_pkg::GrpRra, n6502_pkg::ColZp}, 8'h01, 8'h7F, 8'h00, 8'h00,
                       8'h00, 4'h1, 8'h00, 1'b0));
    send_beat(make_req(n6502_pkg::OpSbcEB, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpSbcEB, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00, 4'h1, 8'h00,
                       1'b0));
    send_beat(make_req({n6502_pkg::GrpIsb, n6502_pkg::ColAbx}, 8'hFF, 8'h00, 8'h00, 8'h00,
                       8'h00, 4'h1, 8'h00, 1'b0));
    send_beat(make_req({n6502_pkg::GrpDcp, n6502_pkg::ColIzx}, 8'h00, 8'hFF, 8'h00, 8'h00,
                       8'h00, 4'h0, 8'h00, 1'b0));
    send_beat(make_req(n6502_pkg::OpArr, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 4'h1, 8'h00,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpAxs, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00,
                       1'b0));
    send_beat(make_req(n6502_pkg::OpAnc0B, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00, 4'h0, 8'h00,
                       1'b0));

    // random beats; mostly covered opcodes, a back-to-back stretch in the middle
    for (i = 0; i < RandomBeats; i++) begin
      if ($urandom_range(99) < 75)
        r.kind = covered_ops[$urandom_range(covered_ops.size() - 1)];
      else
        r.kind = 8'($urandom_range(255));
      r.operand    = pick_byte();
      r.reg_a      = pick_byte();
      r.reg_x      = pick_byte();
      r.reg_y      = pick_byte();
      r.reg_sp     = pick_byte();
      r.flags_in   = 4'($urandom_range(15));
      r.addr_high  = pick_byte();
      r.page_cross = 1'($urandom_range(1));
      if (i < 500 || i >= 800) maybe_idle();
      send_beat(r);
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 8) begin
      @(posedge clk_i);
      drain++;
    end

    $display("ran %0d instruction beats (%0d halts, %0d write-backs, %0d not handled)",
             sb.beats_in, sb.halts, sb.writes, sb.unhandled);
    $display("idle gaps and a back-to-back stretch; %0d results checked, %0d mismatches",
             sb.results_out, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
